// File: sv/mexp_pkg.sv
package mexp_pkg;

  // Width of every operand and of the result.
  localparam int OPERAND_BITS = 31;
  // Width of the bit counter that walks one operand.
  localparam int COUNT_BITS = $clog2(OPERAND_BITS);

  typedef logic [OPERAND_BITS-1:0] mexp_word_t;

  typedef struct packed {
    mexp_word_t base_value;
    mexp_word_t exponent;
    mexp_word_t modulus;
  } mexp_in_t;

  typedef struct packed {
    mexp_word_t power_result;
    logic       modulus_zero_error;
  } mexp_out_t;

  // Operands of one modular multiplication: (addend * scan) mod modulus.
  // The addend must not exceed the modulus; the scanned operand is free.
  typedef struct packed {
    mexp_word_t addend;
    mexp_word_t scan;
    mexp_word_t modulus;
  } mexp_mul_req_t;

endpackage

// File: sv/mexp_modmul.sv
module mexp_modmul (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  input  mexp_pkg::mexp_mul_req_t req,
  output logic                  done,
  output mexp_pkg::mexp_word_t  result
);
  import mexp_pkg::*;

  localparam int TW = OPERAND_BITS + 2;

  logic                  busy_r, busy_nxt;
  logic                  done_r, done_nxt;
  logic [COUNT_BITS-1:0] cnt_r, cnt_nxt;
  mexp_word_t            acc_r, acc_nxt;
  mexp_word_t            add_r, scan_r, scan_nxt, mod_r;

  logic [TW-1:0] sum;
  logic [TW-1:0] mod1;
  logic [TW-1:0] mod2;

  // One step of the interleaved reduction: the partial result stays below the
  // modulus, so doubling it and adding the addend stays below three moduli.
  always_comb begin
    mod1 = {2'b00, mod_r};
    mod2 = {1'b0, mod_r, 1'b0};
    sum  = {1'b0, acc_r, 1'b0} + (scan_r[OPERAND_BITS-1] ? {2'b00, add_r} : '0);
    priority if (sum >= mod2) begin
      acc_nxt = OPERAND_BITS'(sum - mod2);
    end else if (sum >= mod1) begin
      acc_nxt = OPERAND_BITS'(sum - mod1);
    end else begin
      acc_nxt = OPERAND_BITS'(sum);
    end
  end

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    scan_nxt = scan_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
    end else if (busy_r) begin
      scan_nxt = {scan_r[OPERAND_BITS-2:0], 1'b0};
      cnt_nxt  = cnt_r + 1'b1;
      if (cnt_r == COUNT_BITS'(OPERAND_BITS - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      acc_r  <= '0;
      add_r  <= req.addend;
      scan_r <= req.scan;
      mod_r  <= req.modulus;
    end else if (busy_r) begin
      acc_r  <= acc_nxt;
      scan_r <= scan_nxt;
    end
  end

  assign done   = done_r;
  assign result = acc_r;

endmodule

// File: sv/modular_exponentiation_top.sv
// Modular exponentiation, base^exponent mod modulus, by right-to-left binary
// square-and-multiply. A transaction is accepted on a rising edge with start
// high and busy low; busy then stays high until the result is presented.
// The result is shown for exactly one cycle with out_valid high and cannot be
// stalled, so the receiver must capture it in that cycle. Every modular
// multiplication runs on one shared shift-subtract multiplier that consumes
// one bit of its scanned operand per cycle. Each multiplication loads its
// operands, scans every bit of the scanned one and then raises its done
// strobe. A transaction costs one multiplication to reduce the base, then
// for each exponent bit up to the highest set one a squaring plus a
// multiplication where the bit is set (the squaring after the highest bit is
// skipped). With 31-bit operands that is at most 62 multiplications. An
// exponent of zero returns 1 and a zero modulus returns 0 with
// modulus_zero_error set; both go through the finish state without using
// the multiplier.
module modular_exponentiation_top (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  mexp_pkg::mexp_in_t  in_data,
  output logic                out_valid,
  output mexp_pkg::mexp_out_t out_data
);
  import mexp_pkg::*;

  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_REDUCE = 3'd1;
  localparam logic [2:0] ST_MUL    = 3'd2;
  localparam logic [2:0] ST_SQUARE = 3'd3;
  localparam logic [2:0] ST_FINISH = 3'd4;

  logic [2:0]    state_r, state_nxt;
  mexp_word_t    base_r, base_nxt;
  mexp_word_t    exp_r, exp_nxt;
  mexp_word_t    mod_r, mod_nxt;
  mexp_word_t    acc_r, acc_nxt;
  logic          mul_start_r, mul_start_nxt;
  mexp_mul_req_t mul_req_r, mul_req_nxt;
  logic          out_valid_r, out_valid_nxt;
  mexp_out_t     out_r, out_nxt;

  logic       mul_done;
  mexp_word_t mul_result;
  mexp_word_t exp_shift;

  mexp_modmul u_modmul (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (mul_start_r),
    .req    (mul_req_r),
    .done   (mul_done),
    .result (mul_result)
  );

  assign exp_shift = exp_r >> 1;

  always_comb begin
    state_nxt     = state_r;
    base_nxt      = base_r;
    exp_nxt       = exp_r;
    mod_nxt       = mod_r;
    acc_nxt       = acc_r;
    mul_start_nxt = 1'b0;
    mul_req_nxt   = mul_req_r;
    out_valid_nxt = 1'b0;
    out_nxt       = out_r;

    unique case (state_r)
      ST_IDLE: begin
        if (start) begin
          exp_nxt = in_data.exponent;
          mod_nxt = in_data.modulus;
          acc_nxt = OPERAND_BITS'(1);
          if (in_data.modulus == '0) begin
            // Zero modulus wins over a zero exponent.
            out_nxt.power_result       = '0;
            out_nxt.modulus_zero_error = 1'b1;
            state_nxt                  = ST_FINISH;
          end else if (in_data.exponent == '0) begin
            // The running product is returned as is, even for a modulus of one.
            out_nxt.power_result       = OPERAND_BITS'(1);
            out_nxt.modulus_zero_error = 1'b0;
            state_nxt                  = ST_FINISH;
          end else begin
            // Reduce the base as 1 * base mod modulus on the shared multiplier.
            mul_req_nxt.addend  = OPERAND_BITS'(1);
            mul_req_nxt.scan    = in_data.base_value;
            mul_req_nxt.modulus = in_data.modulus;
            mul_start_nxt       = 1'b1;
            state_nxt           = ST_REDUCE;
          end
        end
      end

      ST_REDUCE, ST_SQUARE: begin
        if (mul_done) begin
          base_nxt = mul_result;
          if (state_r == ST_SQUARE) begin
            exp_nxt = exp_shift;
          end
          // Look at the exponent bit that the next round will consume.
          mul_req_nxt.addend  = mul_result;
          mul_req_nxt.modulus = mod_r;
          mul_start_nxt       = 1'b1;
          if ((state_r == ST_SQUARE) ? exp_shift[0] : exp_r[0]) begin
            mul_req_nxt.scan = acc_r;
            state_nxt        = ST_MUL;
          end else begin
            mul_req_nxt.scan = mul_result;
            state_nxt        = ST_SQUARE;
          end
        end
      end

      ST_MUL: begin
        if (mul_done) begin
          acc_nxt = mul_result;
          if (exp_shift == '0) begin
            // Highest set bit done; the last squaring would not be used.
            out_nxt.power_result       = mul_result;
            out_nxt.modulus_zero_error = 1'b0;
            out_valid_nxt              = 1'b1;
            state_nxt                  = ST_IDLE;
          end else begin
            mul_req_nxt.addend  = base_r;
            mul_req_nxt.scan    = base_r;
            mul_req_nxt.modulus = mod_r;
            mul_start_nxt       = 1'b1;
            state_nxt           = ST_SQUARE;
          end
        end
      end

      ST_FINISH: begin
        out_valid_nxt = 1'b1;
        state_nxt     = ST_IDLE;
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      mul_start_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      mul_start_r <= mul_start_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    base_r    <= base_nxt;
    exp_r     <= exp_nxt;
    mod_r     <= mod_nxt;
    acc_r     <= acc_nxt;
    mul_req_r <= mul_req_nxt;
    out_r     <= out_nxt;
  end

  assign busy      = (state_r != ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule
